// ===== hdl/sprs_pkg.sv =====
// ----------------------------------------------------------------------------
// sprs_pkg
// Shared types and constants of the stepper position ramp sequencer: item
// kinds, decoded operations, motion phases and the records passed between
// the front and back parts.
// ----------------------------------------------------------------------------
package sprs_pkg;

    localparam int RAMP_DEPTH_DEF = 256;

    localparam int KIND_W  = 2;
    localparam int INDEX_W = 8;
    localparam int WORD_W  = 16;
    localparam int COUNT_W = 32;
    localparam int LEN_W   = 9;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PULSE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RAMP  = 2'd3;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_START,
        OP_PULSE,
        OP_RAMP
    } op_t;

    typedef enum logic [1:0] {
        PH_STOP  = 2'd0,
        PH_ACCEL = 2'd1,
        PH_FULL  = 2'd2,
        PH_DECEL = 2'd3
    } phase_t;

    typedef struct packed {
        op_t                op;
        logic [INDEX_W-1:0] index;
        logic [WORD_W-1:0]  value;
        logic [COUNT_W-1:0] count;
    } item_t;

    typedef struct packed {
        logic               step_level;
        logic               pulse_on;
        logic               ramp_on;
        logic [WORD_W-1:0]  reload;
        phase_t             phase;
        logic [COUNT_W-1:0] steps_left;
    } result_t;

    typedef struct packed {
        phase_t phase;
        logic   pulse_on;
        logic   ramp_on;
        logic   fetch;
        logic   pop;
    } status_t;

endpackage

// ===== hdl/sprs_ram.sv =====
// ----------------------------------------------------------------------------
// sprs_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module sprs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/sprs_front.sv =====
// ----------------------------------------------------------------------------
// sprs_front
// Input side: decodes each accepted beat into an operation and queues it in
// a two-entry buffer for the back part.
// ----------------------------------------------------------------------------
module sprs_front
    import sprs_pkg::*;
#(
    parameter int RAMP_DEPTH = RAMP_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [KIND_W-1:0]  s_kind,
    input  logic [INDEX_W-1:0] s_table_index,
    input  logic [WORD_W-1:0]  s_table_value,
    input  logic [COUNT_W-1:0] s_step_count,
    output logic               q_valid,
    output item_t              q_item,
    input  logic               q_pop
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    item_t      decoded;
    logic       push;
    logic       index_ok;

    assign index_ok = (32'(s_table_index) < 32'(RAMP_DEPTH));

    always_comb begin
        decoded.index = s_table_index;
        decoded.value = s_table_value;
        decoded.count = s_step_count;
        unique case (s_kind)
            KIND_LOAD:  decoded.op = index_ok ? OP_LOAD : OP_NOP;
            KIND_START: decoded.op = OP_START;
            KIND_PULSE: decoded.op = OP_PULSE;
            KIND_RAMP:  decoded.op = OP_RAMP;
            default:    decoded.op = OP_NOP;
        endcase
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// ===== hdl/sprs_back.sv =====
// ----------------------------------------------------------------------------
// sprs_back
// Execution side: holds move state and ramp table, runs one queued operation
// per cycle unless a fetch or result stall holds it; registers each result.
// ----------------------------------------------------------------------------
module sprs_back
    import sprs_pkg::*;
#(
    parameter int RAMP_DEPTH = RAMP_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_data,
    input  logic             q_valid,
    input  item_t            q_item,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output result_t          m_result,
    output status_t          status
);

    localparam int AW = $clog2(RAMP_DEPTH);
    localparam int CW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;

    phase_t             phase_reg, phase_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [AW-1:0]      last_reg, last_next;
    logic               pend_reg, pend_next;
    logic               pin_reg, pin_next;
    logic [COUNT_W-1:0] remaining_reg, remaining_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [COUNT_W-1:0] half_reg, half_next;
    logic [COUNT_W-1:0] accel_reg, accel_next;
    logic               accel_done_reg, accel_done_next;
    logic               cruising_reg, cruising_next;
    logic               pulse_on_reg, pulse_on_next;
    logic               ramp_on_reg, ramp_on_next;
    logic [WORD_W-1:0]  reload_reg, reload_next;
    logic [WORD_W-1:0]  word_reg, word_next;
    logic               fetch_reg, fetch_next;
    logic               capt_reg, capt_next;
    logic               m_valid_reg, m_valid_next;
    result_t            result_reg, result_next;

    logic [WORD_W-1:0]  word_cur;
    logic [WORD_W-1:0]  ram_rdata;
    logic               ram_we;
    logic [AW-1:0]      load_addr;
    logic [COUNT_W-1:0] rem_dec;
    logic [CW-1:0]      len_eff;

    // word_reg mirrors table[pos_reg]; a fresh read lands in the cycle after fetch
    assign word_cur  = capt_reg ? ram_rdata : word_reg;
    assign load_addr = AW'(q_item.index);
    assign rem_dec   = (remaining_reg != '0) ? remaining_reg - 1'b1 : remaining_reg;
    assign q_pop     = q_valid && !fetch_reg && (!m_valid_reg || m_ready);
    assign ram_we    = q_pop && (q_item.op == OP_LOAD);

    sprs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RAMP_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (load_addr),
        .wdata (q_item.value),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    // clamp the ramp length into one..depth and keep the last valid index
    always_comb begin
        len_eff = CW'(cfg_data);
        if (len_eff == '0) begin
            len_eff = CW'(1);
        end else if (len_eff > CW'(RAMP_DEPTH)) begin
            len_eff = CW'(RAMP_DEPTH);
        end
        last_next = cfg_we ? AW'(len_eff - CW'(1)) : last_reg;
    end

    always_comb begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        pend_next       = pend_reg;
        pin_next        = pin_reg;
        remaining_next  = remaining_reg;
        total_next      = total_reg;
        half_next       = half_reg;
        accel_next      = accel_reg;
        accel_done_next = accel_done_reg;
        cruising_next   = cruising_reg;
        pulse_on_next   = pulse_on_reg;
        ramp_on_next    = ramp_on_reg;
        reload_next     = reload_reg;
        word_next       = word_cur;

        if (q_pop) begin
            unique case (q_item.op)
                OP_LOAD: begin
                    if (load_addr == pos_reg) begin
                        word_next = q_item.value;
                    end
                end
                OP_START: begin
                    if (phase_reg == PH_STOP) begin
                        total_next      = q_item.count;
                        remaining_next  = q_item.count;
                        half_next       = q_item.count >> 1;
                        pos_next        = '0;
                        accel_done_next = 1'b0;
                        cruising_next   = 1'b0;
                        pend_next       = 1'b1;
                        phase_next      = PH_ACCEL;
                        ramp_on_next    = 1'b1;
                        pulse_on_next   = 1'b1;
                    end
                end
                OP_PULSE: begin
                    if (pulse_on_reg) begin
                        pin_next = ~pin_reg;
                        // falling edge of the step pin counts one pulse
                        if (pin_reg) begin
                            remaining_next = rem_dec;
                            if (rem_dec == half_reg && !accel_done_reg) begin
                                phase_next   = PH_DECEL;
                                ramp_on_next = 1'b1;
                            end else if (rem_dec > half_reg && accel_done_reg
                                         && !cruising_reg) begin
                                accel_next    = total_reg - rem_dec;
                                cruising_next = 1'b1;
                            end else if (cruising_reg) begin
                                if (rem_dec == accel_reg + 1'b1) begin
                                    phase_next   = PH_DECEL;
                                    ramp_on_next = 1'b1;
                                end
                            end else if (rem_dec == '0) begin
                                pulse_on_next = 1'b0;
                                pin_next      = 1'b1;
                            end
                        end
                        if (pend_reg) begin
                            reload_next = word_cur;
                            pend_next   = 1'b0;
                        end
                    end
                end
                OP_RAMP: begin
                    if (ramp_on_reg) begin
                        unique case (phase_reg)
                            PH_ACCEL: begin
                                if (pos_reg < last_reg) begin
                                    pend_next = 1'b1;
                                    pos_next  = pos_reg + 1'b1;
                                end else begin
                                    ramp_on_next    = 1'b0;
                                    phase_next      = PH_FULL;
                                    accel_done_next = 1'b1;
                                end
                            end
                            PH_DECEL: begin
                                if (pos_reg != '0) begin
                                    pend_next = 1'b1;
                                    pos_next  = pos_reg - 1'b1;
                                end else begin
                                    ramp_on_next  = 1'b0;
                                    pulse_on_next = 1'b0;
                                    phase_next    = PH_STOP;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end

        // a new ramp index costs a memory read: hold the queue for it
        fetch_next = (pos_next != pos_reg);
        capt_next  = fetch_reg;

        m_valid_next = q_pop ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

        result_next.step_level = pin_next;
        result_next.pulse_on   = pulse_on_next;
        result_next.ramp_on    = ramp_on_next;
        result_next.reload     = reload_next;
        result_next.phase      = phase_next;
        result_next.steps_left = remaining_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_STOP;
            pos_reg        <= '0;
            last_reg       <= '0;
            pend_reg       <= 1'b0;
            pin_reg        <= 1'b1;
            remaining_reg  <= '0;
            total_reg      <= '0;
            half_reg       <= '0;
            accel_reg      <= '0;
            accel_done_reg <= 1'b0;
            cruising_reg   <= 1'b0;
            pulse_on_reg   <= 1'b0;
            ramp_on_reg    <= 1'b0;
            reload_reg     <= '0;
            fetch_reg      <= 1'b0;
            capt_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            last_reg       <= last_next;
            pend_reg       <= pend_next;
            pin_reg        <= pin_next;
            remaining_reg  <= remaining_next;
            total_reg      <= total_next;
            half_reg       <= half_next;
            accel_reg      <= accel_next;
            accel_done_reg <= accel_done_next;
            cruising_reg   <= cruising_next;
            pulse_on_reg   <= pulse_on_next;
            ramp_on_reg    <= ramp_on_next;
            reload_reg     <= reload_next;
            fetch_reg      <= fetch_next;
            capt_reg       <= capt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        if (q_pop) begin
            result_reg <= result_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

    assign status.phase    = phase_reg;
    assign status.pulse_on = pulse_on_reg;
    assign status.ramp_on  = ramp_on_reg;
    assign status.fetch    = fetch_reg;
    assign status.pop      = q_pop;

endmodule

// ===== hdl/stepper_position_ramp_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// stepper_position_ramp_sequencer_unit
// Position-mode stepper move sequencer with a table-driven acceleration ramp.
// ----------------------------------------------------------------------------
// Every accepted beat (ramp word load, move start, pulse-timer event or
// ramp-timer event) yields exactly one result beat carrying the step pin
// level, both timer enables, the current reload word, the motion phase and
// the steps left. Items stream at one per cycle unless a ramp word fetch or
// stalled result holds the queue; each result is registered as its item is
// taken. A ramp event that steps the ramp index makes the execution side read
// the new word from the table before the next queued item; the two-entry
// input queue accepts while it has room. The ramp table needs no clearing
// after reset, but every slot a move reaches must be loaded first. The user
// is to write ramp_length via the cfg port while no item is in flight; the
// block does not enforce it. Zero acts as one, above the depth as the depth.
module stepper_position_ramp_sequencer_unit
    import sprs_pkg::*;
#(
    parameter int RAMP_DEPTH = RAMP_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LEN_W-1:0]   cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [KIND_W-1:0]  s_kind,
    input  logic [INDEX_W-1:0] s_table_index,
    input  logic [WORD_W-1:0]  s_table_value,
    input  logic [COUNT_W-1:0] s_step_count,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_step_level,
    output logic               m_pulse_timer_on,
    output logic               m_ramp_timer_on,
    output logic [WORD_W-1:0]  m_reload_word,
    output logic [1:0]         m_motion_phase,
    output logic [COUNT_W-1:0] m_steps_left
);

    logic    q_valid;
    item_t   q_item;
    logic    q_pop;
    result_t m_result;
    status_t status;

    assign cfg_ready = 1'b1;

    sprs_front #(
        .RAMP_DEPTH (RAMP_DEPTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_table_index (s_table_index),
        .s_table_value (s_table_value),
        .s_step_count  (s_step_count),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    sprs_back #(
        .RAMP_DEPTH (RAMP_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result),
        .status   (status)
    );

    assign m_step_level     = m_result.step_level;
    assign m_pulse_timer_on = m_result.pulse_on;
    assign m_ramp_timer_on  = m_result.ramp_on;
    assign m_reload_word    = m_result.reload;
    assign m_motion_phase   = 2'(m_result.phase);
    assign m_steps_left     = m_result.steps_left;

`ifndef SYNTH
    a_stop_timers_off: assert property (@(posedge aclk) disable iff (!aresetn)
        status.phase == PH_STOP |-> !status.pulse_on && !status.ramp_on)
        else $error("stopped with a timer still enabled");

    a_fetch_holds_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        status.fetch |-> !status.pop)
        else $error("queue popped during ramp word fetch");

    a_pop_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        status.pop |=> m_valid)
        else $error("executed item produced no result beat");
`endif

endmodule
